/* hw/rtl/vts_pkg.sv */
`default_nettype none

package vts_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_CLIMB = 2'd1,
		MODE_SINK  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PAT_ON_FIRST  = 2'd0,
		PAT_GAP_SHORT = 2'd1,
		PAT_ON_SECOND = 2'd2,
		PAT_GAP_LONG  = 2'd3
	} pat_step_t;

	typedef enum logic [3:0] {
		REG_CLIMB_START   = 4'd0,
		REG_CLIMB_STOP    = 4'd1,
		REG_SINK_START    = 4'd2,
		REG_SINK_STOP     = 4'd3,
		REG_CLIMB_BASE_HZ = 4'd4,
		REG_CLIMB_GAIN    = 4'd5,
		REG_SINK_BASE_HZ  = 4'd6,
		REG_SINK_ENABLE   = 4'd7
	} cfg_reg_t;

	localparam int CfgIdxW  = 4;
	localparam int CfgDataW = 12;

	typedef struct packed {
		logic [8:0]         climb_start;
		logic [8:0]         climb_stop;
		logic signed [10:0] sink_start;
		logic signed [10:0] sink_stop;
		logic [11:0]        climb_base_hz;
		logic [9:0]         climb_gain;
		logic [10:0]        sink_base_hz;
		logic               sink_enable;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		climb_start:   9'd20,
		climb_stop:    9'd8,
		sink_start:    -11'sd60,
		sink_stop:     -11'sd20,
		climb_base_hz: 12'd1100,
		climb_gain:    10'd280,
		sink_base_hz:  11'd240,
		sink_enable:   1'b1
	};

	// register clamp limits
	localparam logic [8:0]         ClimbStartMin = 9'd15;
	localparam logic [8:0]         ClimbStartMax = 9'd500;
	localparam logic [8:0]         ClimbStopMin  = 9'd5;
	localparam logic [8:0]         ClimbStopGap  = 9'd3;
	localparam logic signed [10:0] SinkStartMin  = -11'sd800;
	localparam logic signed [10:0] SinkStartMax  = -11'sd40;
	localparam logic signed [10:0] SinkStopMax   = -11'sd1;
	localparam logic [11:0]        BaseHzMin     = 12'd400;
	localparam logic [11:0]        BaseHzMax     = 12'd2500;
	localparam logic [9:0]         GainMin       = 10'd50;
	localparam logic [9:0]         GainMax       = 10'd1000;
	localparam logic [10:0]        SinkHzMin     = 11'd150;
	localparam logic [10:0]        SinkHzMax     = 11'd1200;

	// mode entry counters
	localparam logic [7:0] ClimbEnterCnt = 8'd4;
	localparam logic [7:0] SinkEnterCnt  = 8'd5;
	localparam logic [7:0] CntMax        = 8'd255;

	// climb tone shaping
	localparam logic [15:0] SpeedClipMax  = 16'd800;
	localparam logic [15:0] PeriodBase    = 16'd36000;
	localparam logic [15:0] PeriodSlope   = 16'd55;
	localparam logic [15:0] PeriodKnee    = 16'd27000;
	localparam logic [8:0]  PeriodMin     = 9'd90;
	localparam logic [6:0]  OnBase        = 7'd55;
	localparam logic [6:0]  OnMax         = 7'd80;
	localparam logic [8:0]  ClimbOffReset = 9'd180;
	localparam logic [6:0]  ClimbOnReset  = 7'd60;

	// divide by 100 and by 25 through reciprocals
	localparam logic [20:0] RecipHundredHi = 21'd1342178;
	localparam int          RecipHundredHiShift = 27;
	localparam logic [15:0] RecipHundredLo = 16'd41944;
	localparam int          RecipHundredLoShift = 22;
	localparam logic [10:0] RecipTwentyFive = 11'd1311;
	localparam int          RecipTwentyFiveShift = 15;

	// sink pattern segment lengths, ms
	localparam logic [31:0] SinkOnMs       = 32'd85;
	localparam logic [31:0] SinkShortGapMs = 32'd70;
	localparam logic [31:0] SinkLongGapMs  = 32'd260;

endpackage

`default_nettype wire

/* hw/rtl/vts_sample_if.sv */
`default_nettype none

interface vts_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] speed_cms;
	logic [31:0]        now_ms;

	modport source (output valid, output speed_cms, output now_ms, input ready);
	modport sink (input valid, input speed_cms, input now_ms, output ready);
endinterface

`default_nettype wire

/* hw/rtl/vts_result_if.sv */
`default_nettype none

interface vts_result_if;
	logic        valid;
	logic        ready;
	logic        beep_on;
	logic [13:0] beep_hz;
	logic [1:0]  mode_now;

	modport source (output valid, output beep_on, output beep_hz, output mode_now, input ready);
	modport sink (input valid, input beep_on, input beep_hz, input mode_now, output ready);
endinterface

`default_nettype wire

/* hw/rtl/vts_cfg_if.sv */
`default_nettype none

interface vts_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [vts_pkg::CfgIdxW-1:0]  index;
	logic [vts_pkg::CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/vts_cfg_regs.sv */
`default_nettype none

module vts_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	vts_cfg_if.sink            cfg,
	output vts_pkg::cfg_t      regs
);

	vts_pkg::cfg_t regs_q;
	vts_pkg::cfg_t raw;
	vts_pkg::cfg_t clamped;
	logic          hit;
	logic [8:0]    stop_hi;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_comb begin
		raw = regs_q;
		hit = 1'b1;
		case (cfg.index)
			vts_pkg::REG_CLIMB_START:   raw.climb_start   = cfg.data[8:0];
			vts_pkg::REG_CLIMB_STOP:    raw.climb_stop    = cfg.data[8:0];
			vts_pkg::REG_SINK_START:    raw.sink_start    = $signed(cfg.data[10:0]);
			vts_pkg::REG_SINK_STOP:     raw.sink_stop     = $signed(cfg.data[10:0]);
			vts_pkg::REG_CLIMB_BASE_HZ: raw.climb_base_hz = cfg.data[11:0];
			vts_pkg::REG_CLIMB_GAIN:    raw.climb_gain    = cfg.data[9:0];
			vts_pkg::REG_SINK_BASE_HZ:  raw.sink_base_hz  = cfg.data[10:0];
			vts_pkg::REG_SINK_ENABLE:   raw.sink_enable   = cfg.data[0];
			default:                    hit = 1'b0;
		endcase
	end

	// clamp in list order, stop levels against the new start levels
	always_comb begin
		clamped = raw;
		if (raw.climb_start < vts_pkg::ClimbStartMin) begin
			clamped.climb_start = vts_pkg::ClimbStartMin;
		end else if (raw.climb_start > vts_pkg::ClimbStartMax) begin
			clamped.climb_start = vts_pkg::ClimbStartMax;
		end
		stop_hi = clamped.climb_start - vts_pkg::ClimbStopGap;
		if (raw.climb_stop < vts_pkg::ClimbStopMin) begin
			clamped.climb_stop = vts_pkg::ClimbStopMin;
		end else if (raw.climb_stop > stop_hi) begin
			clamped.climb_stop = stop_hi;
		end
		if (raw.sink_start < vts_pkg::SinkStartMin) begin
			clamped.sink_start = vts_pkg::SinkStartMin;
		end else if (raw.sink_start > vts_pkg::SinkStartMax) begin
			clamped.sink_start = vts_pkg::SinkStartMax;
		end
		if (raw.sink_stop < clamped.sink_start) begin
			clamped.sink_stop = clamped.sink_start;
		end else if (raw.sink_stop > vts_pkg::SinkStopMax) begin
			clamped.sink_stop = vts_pkg::SinkStopMax;
		end
		if (raw.climb_base_hz < vts_pkg::BaseHzMin) begin
			clamped.climb_base_hz = vts_pkg::BaseHzMin;
		end else if (raw.climb_base_hz > vts_pkg::BaseHzMax) begin
			clamped.climb_base_hz = vts_pkg::BaseHzMax;
		end
		if (raw.climb_gain < vts_pkg::GainMin) begin
			clamped.climb_gain = vts_pkg::GainMin;
		end else if (raw.climb_gain > vts_pkg::GainMax) begin
			clamped.climb_gain = vts_pkg::GainMax;
		end
		if (raw.sink_base_hz < vts_pkg::SinkHzMin) begin
			clamped.sink_base_hz = vts_pkg::SinkHzMin;
		end else if (raw.sink_base_hz > vts_pkg::SinkHzMax) begin
			clamped.sink_base_hz = vts_pkg::SinkHzMax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= vts_pkg::CfgReset;
		end else if (cfg.valid && cfg.ready && hit) begin
			regs_q <= clamped;
		end
	end

`ifndef NO_ASSERTIONS
	a_climb_hyst: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q.climb_stop <= regs_q.climb_start - vts_pkg::ClimbStopGap)
		else $error("climb stop level above start minus gap");

	a_sink_hyst: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q.sink_stop >= regs_q.sink_start)
		else $error("sink stop level below sink start");

	a_ignored_index: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && !hit |=> $stable(regs_q))
		else $error("write to unknown index changed registers");
`endif

endmodule

`default_nettype wire

/* hw/rtl/vario_tone_sequencer_unit.sv */
`default_nettype none

// Variometer tone sequencer. Each sample request carries a vertical speed in cm/s and a ms
// timestamp; each one yields exactly one result with the tone flag, the tone frequency and
// the mode (idle, climb, sink). One sample is taken every clock while results are accepted: a
// sample register feeds single-pass compare and multiply logic that writes the result
// register. While a result waits, one more sample can still be taken into the sample
// register; the input stalls only once that register is also held. Configuration writes
// are taken every cycle (ready is held high) and are clamped when written; they are meant
// to happen only while no sample is in flight.

module vario_tone_sequencer_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	vts_sample_if.sink    sample,
	vts_result_if.source  result,
	vts_cfg_if.sink       cfg
);

	vts_pkg::cfg_t      regs;

	// sample stage
	logic               valid_s1;
	logic signed [15:0] speed_s1;
	logic [31:0]        now_s1;
	logic [9:0]         clip_s1;
	logic [15:0]        c55_s1;
	logic [19:0]        prod_s1;

	logic [9:0]         clip_in;
	logic               accept;
	logic               adv;

	// state
	vts_pkg::mode_t     mode_q;
	vts_pkg::pat_step_t step_q;
	logic               beeping_q;
	logic [13:0]        freq_q;
	logic [31:0]        seg_start_q;
	logic [6:0]         on_time_q;
	logic [8:0]         off_time_q;
	logic [7:0]         climb_cnt_q;
	logic [7:0]         sink_cnt_q;

	// result register
	logic               res_valid_q;
	logic               res_beep_q;
	logic [13:0]        res_hz_q;
	vts_pkg::mode_t     res_mode_q;

	// climb tone math
	logic [40:0]        freq_prod;
	logic [15:0]        per_x;
	logic [31:0]        per_prod;
	logic [20:0]        on_prod;
	logic [5:0]         cdiv25;
	logic [13:0]        freq_c;
	logic [8:0]         period_c;
	logic [6:0]         on_c;
	logic [8:0]         off_c;

	// next state
	logic               climb_hit;
	logic               sink_hit;
	logic               climb_exit;
	logic               sink_exit;
	logic signed [16:0] speed_x;
	vts_pkg::mode_t     mode_n;
	vts_pkg::pat_step_t step_n;
	logic               beeping_n;
	logic [13:0]        freq_n;
	logic [31:0]        seg_n;
	logic [6:0]         on_n;
	logic [8:0]         off_n;
	logic [7:0]         climb_cnt_n;
	logic [7:0]         sink_cnt_n;
	logic [31:0]        elapsed;

	vts_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// handshake
	assign adv          = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv;
	assign accept       = sample.valid && sample.ready;

	assign result.valid    = res_valid_q;
	assign result.beep_on  = res_beep_q;
	assign result.beep_hz  = res_hz_q;
	assign result.mode_now = res_mode_q;

	// speed clipped to the climb range on entry
	always_comb begin
		if (sample.speed_cms[15]) begin
			clip_in = 10'd0;
		end else if (sample.speed_cms > $signed(vts_pkg::SpeedClipMax)) begin
			clip_in = vts_pkg::SpeedClipMax[9:0];
		end else begin
			clip_in = sample.speed_cms[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			speed_s1 <= sample.speed_cms;
			now_s1   <= sample.now_ms;
			clip_s1  <= clip_in;
			c55_s1   <= 16'(16'(clip_in) * vts_pkg::PeriodSlope);
			prod_s1  <= 20'(clip_in) * 20'(regs.climb_gain);
		end
	end

	// pitch and cadence
	assign freq_prod = 41'(prod_s1) * 41'(vts_pkg::RecipHundredHi);
	assign freq_c    = 14'(regs.climb_base_hz) + freq_prod[40:vts_pkg::RecipHundredHiShift];
	assign per_x     = vts_pkg::PeriodBase - c55_s1;
	assign per_prod  = per_x * vts_pkg::RecipHundredLo;
	assign period_c  = (c55_s1 > vts_pkg::PeriodKnee) ? vts_pkg::PeriodMin
		: per_prod[vts_pkg::RecipHundredLoShift+8:vts_pkg::RecipHundredLoShift];
	assign on_prod   = 21'(clip_s1) * 21'(vts_pkg::RecipTwentyFive);
	assign cdiv25    = on_prod[vts_pkg::RecipTwentyFiveShift+5:vts_pkg::RecipTwentyFiveShift];
	assign on_c      = (vts_pkg::OnBase + 7'(cdiv25) > vts_pkg::OnMax) ? vts_pkg::OnMax
		: vts_pkg::OnBase + 7'(cdiv25);
	assign off_c     = period_c - 9'(on_c);

	// level compares
	assign speed_x    = {speed_s1[15], speed_s1};
	assign climb_hit  = speed_x >= $signed({8'd0, regs.climb_start});
	assign climb_exit = speed_x <= $signed({8'd0, regs.climb_stop});
	assign sink_hit   = regs.sink_enable
		&& (speed_x <= $signed({{6{regs.sink_start[10]}}, regs.sink_start}));
	assign sink_exit  = speed_x >= $signed({{6{regs.sink_stop[10]}}, regs.sink_stop});

	always_comb begin
		mode_n      = mode_q;
		step_n      = step_q;
		beeping_n   = beeping_q;
		freq_n      = freq_q;
		seg_n       = seg_start_q;
		on_n        = on_time_q;
		off_n       = off_time_q;
		climb_cnt_n = climb_cnt_q;
		sink_cnt_n  = sink_cnt_q;

		case (mode_q)
			vts_pkg::MODE_IDLE: begin
				if (climb_hit) begin
					climb_cnt_n = (climb_cnt_q == vts_pkg::CntMax) ? climb_cnt_q
						: climb_cnt_q + 8'd1;
				end else begin
					climb_cnt_n = 8'd0;
				end
				if (sink_hit) begin
					sink_cnt_n = (sink_cnt_q == vts_pkg::CntMax) ? sink_cnt_q
						: sink_cnt_q + 8'd1;
				end else begin
					sink_cnt_n = 8'd0;
				end
				if (climb_cnt_n >= vts_pkg::ClimbEnterCnt) begin
					mode_n = vts_pkg::MODE_CLIMB;
				end else if (sink_cnt_n >= vts_pkg::SinkEnterCnt) begin
					mode_n = vts_pkg::MODE_SINK;
				end
			end
			vts_pkg::MODE_CLIMB: begin
				if (climb_exit) mode_n = vts_pkg::MODE_IDLE;
			end
			default: begin
				if (sink_exit) mode_n = vts_pkg::MODE_IDLE;
			end
		endcase

		// mode change restarts the sequence
		if (mode_n != mode_q) begin
			beeping_n   = 1'b0;
			freq_n      = 14'd0;
			step_n      = vts_pkg::PAT_ON_FIRST;
			seg_n       = now_s1;
			climb_cnt_n = 8'd0;
			sink_cnt_n  = 8'd0;
			if (mode_n == vts_pkg::MODE_CLIMB) off_n = 9'd0;
		end

		elapsed = now_s1 - seg_n;

		case (mode_n)
			vts_pkg::MODE_IDLE: begin
				freq_n    = 14'd0;
				beeping_n = 1'b0;
			end
			vts_pkg::MODE_CLIMB: begin
				if (beeping_n) begin
					if (elapsed >= 32'(on_n)) begin
						beeping_n = 1'b0;
						off_n     = off_c;
						seg_n     = now_s1;
					end
				end else if (elapsed >= 32'(off_n)) begin
					beeping_n = 1'b1;
					freq_n    = freq_c;
					on_n      = on_c;
					seg_n     = now_s1;
				end
			end
			default: begin
				case (step_n)
					vts_pkg::PAT_ON_FIRST: begin
						if (!beeping_n) begin
							beeping_n = 1'b1;
							freq_n    = 14'(regs.sink_base_hz);
							seg_n     = now_s1;
						end else if (elapsed >= vts_pkg::SinkOnMs) begin
							beeping_n = 1'b0;
							step_n    = vts_pkg::PAT_GAP_SHORT;
							seg_n     = now_s1;
						end
					end
					vts_pkg::PAT_GAP_SHORT: begin
						if (elapsed >= vts_pkg::SinkShortGapMs) begin
							beeping_n = 1'b1;
							freq_n    = 14'(regs.sink_base_hz);
							step_n    = vts_pkg::PAT_ON_SECOND;
							seg_n     = now_s1;
						end
					end
					vts_pkg::PAT_ON_SECOND: begin
						if (elapsed >= vts_pkg::SinkOnMs) begin
							beeping_n = 1'b0;
							step_n    = vts_pkg::PAT_GAP_LONG;
							seg_n     = now_s1;
						end
					end
					default: begin
						if (elapsed >= vts_pkg::SinkLongGapMs) begin
							step_n = vts_pkg::PAT_ON_FIRST;
							seg_n  = now_s1;
						end
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= vts_pkg::MODE_IDLE;
			step_q      <= vts_pkg::PAT_ON_FIRST;
			beeping_q   <= 1'b0;
			freq_q      <= 14'd0;
			seg_start_q <= 32'd0;
			on_time_q   <= vts_pkg::ClimbOnReset;
			off_time_q  <= vts_pkg::ClimbOffReset;
			climb_cnt_q <= 8'd0;
			sink_cnt_q  <= 8'd0;
		end else if (adv) begin
			mode_q      <= mode_n;
			step_q      <= step_n;
			beeping_q   <= beeping_n;
			freq_q      <= freq_n;
			seg_start_q <= seg_n;
			on_time_q   <= on_n;
			off_time_q  <= off_n;
			climb_cnt_q <= climb_cnt_n;
			sink_cnt_q  <= sink_cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_beep_q <= beeping_n;
			res_hz_q   <= freq_n;
			res_mode_q <= mode_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == vts_pkg::MODE_IDLE |->
			climb_cnt_q < vts_pkg::ClimbEnterCnt && sink_cnt_q < vts_pkg::SinkEnterCnt)
		else $error("idle with an entry counter at its threshold");

	a_active_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != vts_pkg::MODE_IDLE |-> climb_cnt_q == 8'd0 && sink_cnt_q == 8'd0)
		else $error("entry counters running outside idle");

	a_pattern_sink: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != vts_pkg::MODE_SINK |-> step_q == vts_pkg::PAT_ON_FIRST)
		else $error("sink pattern advanced outside sink mode");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_mode_q == vts_pkg::MODE_IDLE |-> !res_beep_q && res_hz_q == 14'd0)
		else $error("tone reported in idle");
`endif

endmodule

`default_nettype wire
